/* sv/lz4d_pkg.sv */
// ----------------------------------------------------------------------------
// lz4d_pkg
// Types and constants for the LZ4 block decompressor.
// ----------------------------------------------------------------------------
package lz4d_pkg;

    typedef enum logic [3:0] {
        PH_TOKEN       = 4'd0,
        PH_LITEXT      = 4'd1,
        PH_LIT         = 4'd2,
        PH_OFFLO       = 4'd3,
        PH_OFFHI       = 4'd4,
        PH_MATEXT      = 4'd5,
        PH_COPY        = 4'd6,
        PH_DONE        = 4'd7,
        PH_ERR_TRUNC   = 4'd10,
        PH_ERR_OVERRUN = 4'd11,
        PH_ERR_ZERO    = 4'd12,
        PH_ERR_FAR     = 4'd13,
        PH_ERR_REFUSED = 4'd14
    } phase_t;

    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_FINISHED = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_OVERRUN  = 3'd3;
    localparam logic [2:0] ST_ZERO_OFF = 3'd4;
    localparam logic [2:0] ST_FAR      = 3'd5;
    localparam logic [2:0] ST_REFUSED  = 3'd6;

    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [3:0] NIBBLE_EXT     = 4'hF;
    localparam logic [7:0] BYTE_EXT       = 8'hFF;
    localparam logic [4:0] BASE_MATCH_LEN = 5'd4;

    typedef struct packed {
        logic [7:0]  data;
        logic        copy_pending;
        logic [2:0]  status;
        logic [23:0] produced_count;
    } result_t;

    function automatic logic [2:0] phase_status(input phase_t ph);
        logic [2:0] st;
        case (ph)
            PH_DONE:        st = ST_FINISHED;
            PH_ERR_TRUNC:   st = ST_TRUNC;
            PH_ERR_OVERRUN: st = ST_OVERRUN;
            PH_ERR_ZERO:    st = ST_ZERO_OFF;
            PH_ERR_FAR:     st = ST_FAR;
            PH_ERR_REFUSED: st = ST_REFUSED;
            default:        st = ST_RUNNING;
        endcase
        return st;
    endfunction

endpackage

/* sv/lz4d_history.sv */
// ----------------------------------------------------------------------------
// lz4d_history
// History RAM of decoded bytes: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lz4d_history #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the last read word until the next read request
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/lz4_block_decompressor_top.sv */
// ----------------------------------------------------------------------------
// lz4_block_decompressor_top
// LZ4 block decoder: parses one compressed byte or drains one match byte
// per request, keeping decoded bytes in a history RAM for match copies.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, stage two and the output register; an accepted
// request's result is registered in stage two and moves on when the output is free.
// Throughput: one request per cycle, feed or drain, while the result stream does not stall; the history RAM is read
// once and written once per cycle, with the byte written in the same cycle
// forwarded to an overlapping read (match offset of one).
// Reset (rst_n low, asynchronous) or a write of output_size restarts decoding
// at the token phase with no bytes produced; history contents are kept.
module lz4_block_decompressor_top #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int COUNT_BITS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: output_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] op
    input  logic        s_axis_tlast,   // in_last
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [8] copy_pending,
                                        // [11:9] status, [35:12] produced_count
    output logic        m_axis_tuser    // [0] byte_valid
);
    import lz4d_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = COUNT_BITS;
    localparam int LW = COUNT_BITS + 1;
    localparam int EW = COUNT_BITS + 2;
    localparam logic [16:0] DEPTH17 = 17'(HISTORY_DEPTH);
    localparam logic [17:0] DEPTH18 = 18'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

    // decoder state
    logic [CW-1:0] output_size_reg, output_size_next;
    phase_t        phase_reg, phase_next;
    logic [3:0]    nibble_reg, nibble_next;
    logic [LW-1:0] lit_reg, lit_next;
    logic [15:0]   offset_reg, offset_next;
    logic [LW-1:0] mleft_reg, mleft_next;
    logic [CW-1:0] bytes_reg, bytes_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic          ended_reg, ended_next;

    logic          accept;
    logic          op;
    logic [7:0]    in_b;
    logic          in_last;
    logic          emit;
    logic          drain_emit;
    logic [LW-1:0] ex_arg;
    logic          ex;
    logic          full_now;
    logic          full_inc;
    logic [CW-1:0] bytes_inc;
    logic [15:0]   off_new;
    logic [AW-1:0] src_addr;

    // result pipeline
    logic          s2_valid_reg, s2_valid_next;
    logic          s2_bv_reg;
    logic          s2_drain_reg;
    logic [7:0]    s2_lit_reg;
    logic          s2_hit_reg;
    logic [7:0]    s2_fwd_reg;
    logic          s2_cp_reg;
    logic [2:0]    s2_status_reg;
    logic [23:0]   s2_count_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [7:0]    s2_byte;
    logic          s2_adv;
    logic          out_free;
    logic          out_valid_reg, out_valid_next;
    logic          out_user_reg;
    result_t       out_data_reg;
    result_t       s2_result;
    logic [7:0]    rd_data;

    assign op      = s_axis_tuser;
    assign in_b    = s_axis_tdata;
    assign in_last = s_axis_tlast;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_adv        = s2_valid_reg && out_free;
    assign s_axis_tready = !s2_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // overrun test: one add and compare on a muxed count
    always_comb
    begin
        case (phase_reg)
            PH_TOKEN:  ex_arg = LW'(in_b[7:4]);
            PH_LITEXT: ex_arg = lit_reg + LW'(in_b);
            PH_OFFHI:  ex_arg = LW'(nibble_reg) + LW'(BASE_MATCH_LEN);
            PH_MATEXT: ex_arg = mleft_reg + LW'(in_b);
            default:   ex_arg = '0;
        endcase
    end

    assign ex        = (EW'(bytes_reg) + EW'(ex_arg)) > EW'(output_size_reg);
    assign bytes_inc = bytes_reg + CW'(1);
    assign full_now  = (bytes_reg == output_size_reg);
    assign full_inc  = (bytes_inc == output_size_reg);
    assign off_new   = {in_b, offset_reg[7:0]};

    // source of a match byte, modulo the history depth
    always_comb
    begin
        if (18'(wptr_reg) >= 18'(offset_reg))
        begin
            src_addr = AW'(18'(wptr_reg) - 18'(offset_reg));
        end
        else
        begin
            src_addr = AW'(18'(wptr_reg) + DEPTH18 - 18'(offset_reg));
        end
    end

    // next decoder state
    always_comb
    begin
        output_size_next = output_size_reg;
        phase_next       = phase_reg;
        nibble_next      = nibble_reg;
        lit_next         = lit_reg;
        offset_next      = offset_reg;
        mleft_next       = mleft_reg;
        bytes_next       = bytes_reg;
        wptr_next        = wptr_reg;
        ended_next       = ended_reg;
        emit             = 1'b0;
        drain_emit       = 1'b0;

        if (accept && (phase_reg < PH_DONE))
        begin
            if (op == OP_FEED)
            begin
                case (phase_reg)
                    PH_TOKEN:
                    begin
                        nibble_next = in_b[3:0];
                        lit_next    = LW'(in_b[7:4]);
                        if (in_b[7:4] == NIBBLE_EXT)
                        begin
                            if (ex)
                                phase_next = PH_ERR_OVERRUN;
                            else if (in_last)
                                phase_next = PH_ERR_TRUNC;
                            else
                                phase_next = PH_LITEXT;
                        end
                        else if (in_b[7:4] != 4'd0)
                        begin
                            if (ex)
                                phase_next = PH_ERR_OVERRUN;
                            else if (in_last)
                                phase_next = PH_ERR_TRUNC;
                            else
                                phase_next = PH_LIT;
                        end
                        else if (full_now)
                            phase_next = PH_DONE;
                        else if (in_last)
                            phase_next = PH_ERR_TRUNC;
                        else
                            phase_next = PH_OFFLO;
                    end
                    PH_LITEXT:
                    begin
                        lit_next = ex_arg;
                        if (ex)
                            phase_next = PH_ERR_OVERRUN;
                        else if (in_b == BYTE_EXT)
                        begin
                            if (in_last)
                                phase_next = PH_ERR_TRUNC;
                        end
                        else if (ex_arg != '0)
                        begin
                            if (in_last)
                                phase_next = PH_ERR_TRUNC;
                            else
                                phase_next = PH_LIT;
                        end
                        else if (full_now)
                            phase_next = PH_DONE;
                        else if (in_last)
                            phase_next = PH_ERR_TRUNC;
                        else
                            phase_next = PH_OFFLO;
                    end
                    PH_LIT:
                    begin
                        emit     = 1'b1;
                        lit_next = lit_reg - LW'(1);
                        if (lit_reg == LW'(1))
                        begin
                            if (full_inc)
                                phase_next = PH_DONE;
                            else if (in_last)
                                phase_next = PH_ERR_TRUNC;
                            else
                                phase_next = PH_OFFLO;
                        end
                        else if (in_last)
                            phase_next = PH_ERR_TRUNC;
                    end
                    PH_OFFLO:
                    begin
                        offset_next = {8'h00, in_b};
                        phase_next  = in_last ? PH_ERR_TRUNC : PH_OFFHI;
                    end
                    PH_OFFHI:
                    begin
                        offset_next = off_new;
                        if (off_new == 16'd0)
                            phase_next = PH_ERR_ZERO;
                        else if ((32'(off_new) > 32'(bytes_reg)) ||
                                 ({1'b0, off_new} > DEPTH17))
                            phase_next = PH_ERR_FAR;
                        else
                        begin
                            mleft_next = ex_arg;
                            if (ex)
                                phase_next = PH_ERR_OVERRUN;
                            else if (nibble_reg == NIBBLE_EXT)
                                phase_next = in_last ? PH_ERR_TRUNC : PH_MATEXT;
                            else
                            begin
                                phase_next = PH_COPY;
                                ended_next = in_last;
                            end
                        end
                    end
                    PH_MATEXT:
                    begin
                        mleft_next = ex_arg;
                        if (ex)
                            phase_next = PH_ERR_OVERRUN;
                        else if (in_b == BYTE_EXT)
                        begin
                            if (in_last)
                                phase_next = PH_ERR_TRUNC;
                        end
                        else
                        begin
                            phase_next = PH_COPY;
                            ended_next = in_last;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ERR_REFUSED;
                    end
                endcase
            end
            else if (phase_reg != PH_COPY)
            begin
                phase_next = PH_ERR_REFUSED;
            end
            else
            begin
                emit       = 1'b1;
                drain_emit = 1'b1;
                mleft_next = mleft_reg - LW'(1);
                if (mleft_reg == LW'(1))
                    phase_next = ended_reg ? PH_DONE : PH_TOKEN;
            end
        end

        if (emit)
        begin
            bytes_next = bytes_inc;
            wptr_next  = (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + AW'(1);
        end

        // restart on a size write
        if (cfg_valid)
        begin
            output_size_next = CW'(cfg_data);
            phase_next       = PH_TOKEN;
            nibble_next      = '0;
            lit_next         = '0;
            offset_next      = '0;
            mleft_next       = '0;
            bytes_next       = '0;
            wptr_next        = '0;
            ended_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_size_reg <= '0;
            phase_reg       <= PH_TOKEN;
            nibble_reg      <= '0;
            lit_reg         <= '0;
            offset_reg      <= '0;
            mleft_reg       <= '0;
            bytes_reg       <= '0;
            wptr_reg        <= '0;
            ended_reg       <= 1'b0;
        end
        else
        begin
            output_size_reg <= output_size_next;
            phase_reg       <= phase_next;
            nibble_reg      <= nibble_next;
            lit_reg         <= lit_next;
            offset_reg      <= offset_next;
            mleft_reg       <= mleft_next;
            bytes_reg       <= bytes_next;
            wptr_reg        <= wptr_next;
            ended_reg       <= ended_next;
        end
    end

    // second stage: pick literal, RAM word or forwarded byte, or zero when no byte
    always_comb
    begin
        if (!s2_bv_reg)
            s2_byte = 8'h00;
        else if (!s2_drain_reg)
            s2_byte = s2_lit_reg;
        else if (s2_hit_reg)
            s2_byte = s2_fwd_reg;
        else
            s2_byte = rd_data;
    end

    always_comb
    begin
        s2_result.data           = s2_byte;
        s2_result.copy_pending   = s2_cp_reg;
        s2_result.status         = s2_status_reg;
        s2_result.produced_count = s2_count_reg;
    end

    always_comb
    begin
        if (accept)
            s2_valid_next = 1'b1;
        else if (s2_adv)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;

        if (s2_adv)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_bv_reg     <= emit;
            s2_drain_reg  <= drain_emit;
            s2_lit_reg    <= in_b;
            // the byte leaving stage two now is written this edge: forward it
            s2_hit_reg    <= s2_valid_reg && s2_bv_reg && (src_addr == s2_addr_reg);
            s2_fwd_reg    <= s2_byte;
            s2_cp_reg     <= (phase_next == PH_COPY);
            s2_status_reg <= phase_status(phase_next);
            s2_count_reg  <= 24'(bytes_next);
            s2_addr_reg   <= wptr_reg;
        end
        if (s2_adv)
        begin
            out_user_reg <= s2_bv_reg;
            out_data_reg <= s2_result;
        end
    end

    lz4d_history #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_history (
        .clk     (clk),
        .wr_en   (s2_adv && s2_bv_reg),
        .wr_addr (s2_addr_reg),
        .wr_data (s2_byte),
        .rd_en   (drain_emit),
        .rd_addr (src_addr),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = {4'h0, out_data_reg.produced_count, out_data_reg.status,
                            out_data_reg.copy_pending, out_data_reg.data};

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZ4 block decompressor. Streams of compressed
// bytes and match-drain requests are built in the bench, mostly well-formed
// blocks with random literals and matches, the rest truncated, mis-sized or
// corrupted. A decoder model inside the bench predicts every result, and each
// result taken from the output stream is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lz4d_pkg::*;

    localparam int HIST_DEPTH = 65536;
    localparam int RANDOM_REQS = 1600;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       last;
    } dec_req_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        copy_pending;
        logic [2:0]  status;
        logic [23:0] produced;
    } dec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    lz4_block_decompressor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // decoder model state
    phase_t      ph;
    logic [3:0]  m_nib;
    int unsigned lit_left;
    int unsigned mat_left;
    logic [15:0] m_off;
    int unsigned n_out;
    logic        in_end;
    bit          ended;
    logic [2:0]  end_st;
    int unsigned out_size;
    logic [7:0]  hist [0:HIST_DEPTH-1];
    bit          hit_byte;
    logic [7:0]  hit_val;

    dec_result_t decoded_q[$];
    dec_req_t    blk_q[$];
    int          off_at[$];

    bit no_idle = 1'b0;
    int sent_reqs = 0;
    int live_reqs = 0;
    int results_seen = 0;
    int mismatches = 0;
    int size_writes = 0;
    int blocks = 0;
    int ends [7] = '{default: 0};

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function automatic void restart_decoder();
        ph = PH_TOKEN;
        m_nib = '0;
        lit_left = 0;
        mat_left = 0;
        m_off = '0;
        n_out = 0;
        in_end = 1'b0;
        ended = 1'b0;
        end_st = ST_RUNNING;
    endfunction

    function automatic void halt(input logic [2:0] st);
        ended = 1'b1;
        end_st = st;
    endfunction

    function automatic bit over(input int unsigned cnt);
        return (64'(n_out) + 64'(cnt)) > 64'(out_size);
    endfunction

    function automatic void record_byte(input logic [7:0] b);
        hist[n_out[15:0]] = b;
        n_out = (n_out + 1) & 32'h00FF_FFFF;
        hit_byte = 1'b1;
        hit_val = b;
    endfunction

    function automatic void after_lits(input logic last);
        if (n_out == out_size)
            halt(ST_FINISHED);
        else if (last)
            halt(ST_TRUNC);
        else
            ph = PH_OFFLO;
    endfunction

    function automatic void after_litlen(input logic last);
        if (lit_left > 0)
        begin
            if (over(lit_left))
                halt(ST_OVERRUN);
            else if (last)
                halt(ST_TRUNC);
            else
                ph = PH_LIT;
        end
        else
            after_lits(last);
    endfunction

    function automatic void after_matlen(input logic last);
        if (over(mat_left))
            halt(ST_OVERRUN);
        else
        begin
            ph = PH_COPY;
            in_end = last;
        end
    endfunction

    // Advance the model by one request and queue the result it must produce.
    function automatic bit decode_step(input dec_req_t r);
        dec_result_t res;
        logic [15:0] src;
        bit          live;
        res = '0;
        hit_byte = 1'b0;
        hit_val = '0;
        live = !ended;
        if (live && r.op == OP_DRAIN)
        begin
            if (ph != PH_COPY)
                halt(ST_REFUSED);
            else
            begin
                src = n_out[15:0] - m_off;
                record_byte(hist[src]);
                mat_left--;
                if (mat_left == 0)
                begin
                    if (in_end)
                        halt(ST_FINISHED);
                    else
                        ph = PH_TOKEN;
                end
            end
        end
        else if (live)
        begin
            case (ph)
                PH_TOKEN:
                begin
                    m_nib = r.data[3:0];
                    lit_left = 32'(r.data[7:4]);
                    if (r.data[7:4] == NIBBLE_EXT)
                    begin
                        if (over(lit_left))
                            halt(ST_OVERRUN);
                        else if (r.last)
                            halt(ST_TRUNC);
                        else
                            ph = PH_LITEXT;
                    end
                    else
                        after_litlen(r.last);
                end
                PH_LITEXT:
                begin
                    lit_left += 32'(r.data);
                    if (over(lit_left))
                        halt(ST_OVERRUN);
                    else if (r.data == BYTE_EXT)
                    begin
                        if (r.last)
                            halt(ST_TRUNC);
                    end
                    else
                        after_litlen(r.last);
                end
                PH_LIT:
                begin
                    record_byte(r.data);
                    lit_left--;
                    if (lit_left == 0)
                        after_lits(r.last);
                    else if (r.last)
                        halt(ST_TRUNC);
                end
                PH_OFFLO:
                begin
                    m_off = {8'h00, r.data};
                    if (r.last)
                        halt(ST_TRUNC);
                    else
                        ph = PH_OFFHI;
                end
                PH_OFFHI:
                begin
                    m_off[15:8] = r.data;
                    if (m_off == 0)
                        halt(ST_ZERO_OFF);
                    else if (m_off > n_out || m_off > HIST_DEPTH)
                        halt(ST_FAR);
                    else
                    begin
                        mat_left = 32'(m_nib) + 32'(BASE_MATCH_LEN);
                        if (m_nib == NIBBLE_EXT)
                        begin
                            if (over(mat_left))
                                halt(ST_OVERRUN);
                            else if (r.last)
                                halt(ST_TRUNC);
                            else
                                ph = PH_MATEXT;
                        end
                        else
                            after_matlen(r.last);
                    end
                end
                PH_MATEXT:
                begin
                    mat_left += 32'(r.data);
                    if (over(mat_left))
                        halt(ST_OVERRUN);
                    else if (r.data == BYTE_EXT)
                    begin
                        if (r.last)
                            halt(ST_TRUNC);
                    end
                    else
                        after_matlen(r.last);
                end
                default:
                    halt(ST_REFUSED);
            endcase
        end
        res.byte_valid = hit_byte;
        res.out_byte = hit_val;
        res.copy_pending = !ended && ph == PH_COPY;
        res.status = ended ? end_st : ST_RUNNING;
        res.produced = n_out[23:0];
        decoded_q.push_back(res);
        return live;
    endfunction

    // ------------------------------------------------------------------
    // stream building
    // ------------------------------------------------------------------
    function automatic int idle_cycles();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic int pick_len(input bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (wide && r < 12)
            return $urandom_range(250, 560);
        if (r < 70)
            return $urandom_range(0, 8);
        if (r < 92)
            return $urandom_range(9, 20);
        return $urandom_range(21, 60);
    endfunction

    function automatic dec_req_t noise_req();
        return '{op: 1'($urandom_range(0, 1)), data: 8'($urandom_range(0, 255)),
                 last: ($urandom_range(0, 3) == 0)};
    endfunction

    function automatic void push_feed(input logic [7:0] b);
        blk_q.push_back('{op: OP_FEED, data: b, last: 1'b0});
    endfunction

    // Drain requests carry junk in the byte and last fields; both are ignored.
    function automatic void push_drain();
        blk_q.push_back('{op: OP_DRAIN, data: 8'($urandom_range(0, 255)),
                          last: ($urandom_range(0, 7) == 0)});
    endfunction

    function automatic void push_ext(input int n);
        while (n >= 255)
        begin
            push_feed(BYTE_EXT);
            n -= 255;
        end
        push_feed(n[7:0]);
    endfunction

    function automatic void push_seq_head(input int lit, input int mnib);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = (lit >= 15) ? NIBBLE_EXT : lit[3:0];
        lo = (mnib >= 15) ? NIBBLE_EXT : mnib[3:0];
        push_feed({hi, lo});
        if (lit >= 15)
            push_ext(lit - 15);
        repeat (lit)
            push_feed(8'($urandom_range(0, 255)));
    endfunction

    function automatic void mark_last();
        for (int i = blk_q.size() - 1; i >= 0; i--)
        begin
            if (blk_q[i].op == OP_FEED)
            begin
                blk_q[i].last = 1'b1;
                break;
            end
        end
    endfunction

    // Build a well-formed block: n_seq match sequences, then either a
    // literal-only tail or an input end on the last match's final field byte.
    function automatic int build_block(input int n_seq, input bit end_by_input,
                                       input bit wide);
        int made;
        int lit;
        int mat;
        int back;
        int lim;
        blk_q.delete();
        off_at.delete();
        made = 0;
        for (int s = 0; s < n_seq; s++)
        begin
            lit = pick_len(wide);
            if (s == 0 && lit == 0)
                lit = 1;
            mat = pick_len(wide) + BASE_MATCH_LEN;
            push_seq_head(lit, mat - BASE_MATCH_LEN);
            made += lit;
            lim = (made < 65535) ? made : 65535;
            // favor short distances so overlapping copies are common
            if ($urandom_range(0, 2) == 0)
                back = $urandom_range(1, (lim < 4) ? lim : 4);
            else
                back = $urandom_range(1, lim);
            off_at.push_back(blk_q.size());
            push_feed(back[7:0]);
            push_feed(back[15:8]);
            if (mat - BASE_MATCH_LEN >= 15)
                push_ext(mat - BASE_MATCH_LEN - 15);
            if (end_by_input && s == n_seq - 1)
                mark_last();
            repeat (mat)
                push_drain();
            made += mat;
        end
        if (!end_by_input)
        begin
            lit = pick_len(wide);
            push_seq_head(lit, $urandom_range(0, 15));
            made += lit;
            if ($urandom_range(0, 1) == 1)
                mark_last();
        end
        return made;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic send_req(input dec_req_t r);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= r.data;
        s_axis_tuser <= r.op;
        s_axis_tlast <= r.last;
        do @(posedge clk); while (!s_axis_tready);
        if (decode_step(r))
            live_reqs++;
        sent_reqs++;
    endtask

    // Hold off until every predicted result is back, then let the pipe empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        blocks++;
        ends[ended ? end_st : ST_RUNNING]++;
    endtask

    task automatic write_size(input logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        out_size = 32'(v);
        restart_decoder();
        size_writes++;
    endtask

    task automatic run_block(input logic [23:0] osize, input int extra);
        write_size(osize);
        foreach (blk_q[i])
            send_req(blk_q[i]);
        repeat (extra)
            send_req(noise_req());
        settle();
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input dec_result_t want, input dec_result_t got,
                                 input bit unexpected);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (unexpected)
                $display("[%0t] result with nothing outstanding: valid=%0b byte=%02h",
                         $realtime, got.byte_valid, got.out_byte);
            else
                $display("[%0t] result %0d: expected valid=%0b byte=%02h copy=%0b st=%0d cnt=%0d",
                         $realtime, results_seen, want.byte_valid, want.out_byte,
                         want.copy_pending, want.status, want.produced);
            if (!unexpected)
                $display("            got      valid=%0b byte=%02h copy=%0b st=%0d cnt=%0d",
                         got.byte_valid, got.out_byte, got.copy_pending, got.status,
                         got.produced);
        end
    endtask

    always @(posedge clk)
    begin : check_result
        dec_result_t got;
        dec_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{byte_valid: m_axis_tuser, out_byte: m_axis_tdata[7:0],
                    copy_pending: m_axis_tdata[8], status: m_axis_tdata[11:9],
                    produced: m_axis_tdata[35:12]};
            if (decoded_q.size() == 0)
                note_mismatch('0, got, 1'b1);
            else
            begin
                want = decoded_q.pop_front();
                if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte
                    || got.copy_pending !== want.copy_pending
                    || got.status !== want.status || got.produced !== want.produced)
                    note_mismatch(want, got, 1'b0);
            end
            results_seen++;
        end
    end

    // Result side: ready bursts broken by random stalls.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (!no_idle && $urandom_range(0, 1) == 1)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 3))
                    @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // Size register is zero out of reset: an empty token finishes at once.
    task automatic test_reset_default();
        send_req('{op: OP_FEED, data: 8'h00, last: 1'b1});
        send_req('{op: OP_DRAIN, data: 8'hFF, last: 1'b0});
        settle();
    endtask

    // Two literals at the byte extremes, an overlapping copy at distance one,
    // and a closing token with no literals once the output is full.
    task automatic test_basic_block();
        blk_q.delete();
        push_feed(8'h21);
        push_feed(8'h00);
        push_feed(8'hFF);
        push_feed(8'h01);
        push_feed(8'h00);
        repeat (5) push_drain();
        push_feed(8'h00);
        mark_last();
        run_block(24'd7, 0);
    endtask

    // Input ends on the offset; the match still drains, then decoding finishes.
    task automatic test_input_end_in_match();
        blk_q.delete();
        push_feed(8'h10);
        push_feed(8'hA5);
        push_feed(8'h01);
        push_feed(8'h00);
        mark_last();
        repeat (4) push_drain();
        run_block(24'd1000, 0);
    endtask

    task automatic test_error_cases();
        // zero offset, then one request after the sticky end
        blk_q.delete();
        push_feed(8'h10);
        push_feed(8'h41);
        push_feed(8'h00);
        push_feed(8'h00);
        run_block(24'd9, 1);
        // literals promised but input ends on the token
        blk_q.delete();
        push_feed(8'h30);
        mark_last();
        run_block(24'd9, 0);
        // literal count already past the expected size
        blk_q.delete();
        push_feed(8'hF0);
        run_block(24'd3, 0);
        // drain with no match pending
        blk_q.delete();
        push_drain();
        run_block(24'd9, 0);
    endtask

    task automatic test_size_extremes();
        void'(build_block(2, 1'b1, 1'b0));
        run_block(24'hFF_FFFF, 1);
        blk_q.delete();
        push_feed(8'h00);
        mark_last();
        run_block(24'd0, 1);
        blk_q.delete();
        push_feed(8'h10);
        run_block(24'd0, 0);
    endtask

    // Mostly well-formed blocks; the rest mis-sized, cut short or corrupted.
    task automatic test_random_blocks();
        int kind;
        int n_seq;
        int total;
        int k;
        int p;
        bit wide;
        bit end_in;
        logic [23:0] osize;
        while (sent_reqs < RANDOM_REQS)
        begin
            // keep long blocks away from the end of the run
            wide = (RANDOM_REQS - sent_reqs > 800) && ($urandom_range(0, 99) < 12);
            n_seq = wide ? $urandom_range(1, 2) : $urandom_range(0, 5);
            end_in = (n_seq > 0) && ($urandom_range(0, 3) == 0);
            total = build_block(n_seq, end_in, wide);
            osize = end_in ? 24'(total + $urandom_range(0, 40)) : 24'(total);
            kind = $urandom_range(0, 99);
            if (kind < 60)
                ;
            else if (kind < 66)
                osize = (total == 0) ? 24'd0 : 24'($urandom_range(0, total - 1));
            else if (kind < 74)
            begin
                // cut the stream at a feed byte and flag it as the last one
                k = $urandom_range(0, blk_q.size() - 1);
                while (k > 0 && blk_q[k].op == OP_DRAIN)
                    k--;
                while (blk_q.size() > k + 1)
                    void'(blk_q.pop_back());
                mark_last();
            end
            else if (kind < 84 && off_at.size() > 0)
            begin
                p = off_at[$urandom_range(0, off_at.size() - 1)];
                if (kind < 79)
                begin
                    blk_q[p].data = 8'h00;
                    blk_q[p + 1].data = 8'h00;
                end
                else
                begin
                    blk_q[p].data = 8'($urandom_range(0, 255));
                    blk_q[p + 1].data = 8'($urandom_range(1, 255));
                end
            end
            else if (kind < 89)
                blk_q.insert($urandom_range(0, blk_q.size()),
                             '{op: OP_DRAIN, data: 8'h00, last: 1'b0});
            else if (kind < 94)
            begin
                // drop one drain so a later feed lands while a match is pending
                for (int i = $urandom_range(0, blk_q.size() - 1); i < blk_q.size(); i++)
                begin
                    if (blk_q[i].op == OP_DRAIN)
                    begin
                        blk_q.delete(i);
                        break;
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    blk_q[$urandom_range(0, blk_q.size() - 1)] = noise_req();
            end
            no_idle = ($urandom_range(0, 4) == 0);
            run_block(osize, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        restart_decoder();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_default();
        test_basic_block();
        test_input_end_in_match();
        test_error_cases();
        test_size_extremes();
        test_random_blocks();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("decoded %0d blocks from %0d requests (%0d while decoding), %0d results,",
                 blocks, sent_reqs, live_reqs, results_seen, " %0d size writes",
                 size_writes);
        $display("block endings: running %0d, finished %0d, truncated %0d, overrun %0d,",
                 ends[ST_RUNNING], ends[ST_FINISHED], ends[ST_TRUNC], ends[ST_OVERRUN],
                 " zero offset %0d, far offset %0d, refused %0d",
                 ends[ST_ZERO_OFF], ends[ST_FAR], ends[ST_REFUSED]);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", decoded_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/lz4d_pkg.sv
sv/lz4d_history.sv
sv/lz4_block_decompressor_top.sv
bench/tb_top.sv
